### rtl/bpf_pkg.sv
// Package for the Bezier path flattener: widths, command and result codes,
// and the coordinate saturation helper. No dependencies.
package bpf_pkg;

  // Coordinate and field widths
  localparam int CoordW    = 32;
  localparam int CoordBits = 32;
  localparam int TypeW     = 3;
  localparam int KindW     = 2;
  localparam int TolW      = 24;

  // Configuration port
  localparam int ApbAW = 3;
  localparam int ApbDW = 32;
  localparam logic [TolW-1:0] TolReset = 24'd16384;
  localparam logic RegTolerance = 1'b0;

  // Parameter defaults
  localparam int MaxSegmentsDef = 64;

  // Q1.16 parameter t and step dt
  localparam int TW = 17;
  localparam logic [TW-1:0] OneQ16 = 17'h10000;

  // Curvature bound datapath
  localparam int VecW  = 37;
  localparam int MagW  = 31;
  localparam int ShW   = 3;
  localparam int LenW  = 37;
  localparam int NumW  = 58;
  localparam int RadW  = 64;
  localparam int RootW = 32;
  localparam int KW    = 42;
  localparam logic [KW-1:0] Sqrt8Q16 = 42'd185364;

  // Shared multiplier
  localparam int MulAW = 34;
  localparam int MulBW = 31;
  localparam int MulPW = 65;

  // Command kinds
  localparam logic [TypeW-1:0] ReqMove  = 3'd0;
  localparam logic [TypeW-1:0] ReqLine  = 3'd1;
  localparam logic [TypeW-1:0] ReqQuad  = 3'd2;
  localparam logic [TypeW-1:0] ReqCubic = 3'd3;

  // Result kinds
  localparam logic [KindW-1:0] SegMove  = 2'd0;
  localparam logic [KindW-1:0] SegLine  = 2'd1;
  localparam logic [KindW-1:0] SegUnsup = 2'd2;

  // Saturation bounds for a signed CoordBits-bit coordinate
  localparam int SatSh = (CoordBits >= CoordW) ? CoordW - 1 : CoordBits - 1;
  localparam logic signed [CoordW-1:0] SatHi = CoordW'((64'sd1 <<< SatSh) - 64'sd1);
  localparam logic signed [CoordW-1:0] SatLo = -SatHi - CoordW'(1);

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [CoordW-1:0] v);
    logic signed [CoordW-1:0] r;
    r = v;
    if (v > SatHi) r = SatHi;
    if (v < SatLo) r = SatLo;
    return r;
  endfunction

endpackage

### rtl/bpf_if.sv
// Valid/ready channels of the Bezier path flattener: the command input and the
// point output. Depends on bpf_pkg.
interface bpf_req_if;
  import bpf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [TypeW-1:0]         req_type;
  logic signed [CoordW-1:0] p1_x;
  logic signed [CoordW-1:0] p1_y;
  logic signed [CoordW-1:0] p2_x;
  logic signed [CoordW-1:0] p2_y;
  logic signed [CoordW-1:0] p3_x;
  logic signed [CoordW-1:0] p3_y;
  modport source (output valid, req_type, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, input ready);
  modport sink (input valid, req_type, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, output ready);
endinterface

interface bpf_res_if;
  import bpf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] out_x;
  logic signed [CoordW-1:0] out_y;
  logic [KindW-1:0]         seg_kind;
  logic                     last_of_run;
  modport source (output valid, out_x, out_y, seg_kind, last_of_run, input ready);
  modport sink (input valid, out_x, out_y, seg_kind, last_of_run, output ready);
endinterface

### rtl/bezier_path_flattener_unit.sv
// Top level of the Bezier path flattener: command sequencer, current point and
// de Casteljau work registers. Depends on bpf_pkg, bpf_if, bpf_cfg, bpf_mul,
// bpf_div and bpf_sqrt.
//
// Usage: path commands arrive on req_i, one item per valid/ready handshake.
// Move and line give one point; every other kind gives one item flagged
// unsupported at the current point. Quadratic and cubic curves give
// one line-to point per parameter step, and last_of_run marks the final item
// of each command. The tolerance register sits on the APB port at offset 0.
// Rate: one command at a time; req_i.ready is high only while idle. The step
// size is set by the bit-serial square root and divider; each point's
// interpolations run on the one shared multiplier.
// Reset: the current point is cleared to the origin and the tolerance is set
// to 0.25. A stalled receiver holds the pending point and halts the sequencer.
module bezier_path_flattener_unit #(
  parameter int MAX_SEGMENTS = bpf_pkg::MaxSegmentsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bpf_req_if.sink                    req_i,
  bpf_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpf_pkg::ApbAW-1:0]  paddr,
  input  logic [bpf_pkg::ApbDW-1:0]  pwdata,
  output logic [bpf_pkg::ApbDW-1:0]  prdata,
  output logic                       pready
);
  import bpf_pkg::*;

  localparam int SegW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [TW-1:0] DtMin = TW'((65536 + MAX_SEGMENTS - 1) / MAX_SEGMENTS);

  typedef enum logic [14:0] {
    StIdle = 15'b000000000000001,
    StVec  = 15'b000000000000010,
    StNorm = 15'b000000000000100,
    StSqX  = 15'b000000000001000,
    StSqY  = 15'b000000000010000,
    StSqS  = 15'b000000000100000,
    StRoot = 15'b000000001000000,
    StDiv  = 15'b000000010000000,
    StDtSq = 15'b000000100000000,
    StPt   = 15'b000001000000000,
    StLx   = 15'b000010000000000,
    StLy   = 15'b000100000000000,
    StLw   = 15'b001000000000000,
    StDrop = 15'b010000000000000,
    StEmit = 15'b100000000000000
  } state_e;

  // Control state
  state_e           state_q, state_d;
  logic             cubic_q, cubic_d;
  logic             pass_q, pass_d;
  logic [SegW-1:0]  seg_q, seg_d;
  logic [TW-1:0]    t_q, t_d;
  logic [2:0]       n_q, n_d;
  logic [1:0]       k_q, k_d;
  logic signed [CoordW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;

  // Datapath registers
  logic signed [CoordW-1:0] px_q [4], px_d [4], py_q [4], py_d [4];
  logic signed [CoordW-1:0] wx_q [4], wx_d [4], wy_q [4], wy_d [4];
  logic signed [VecW-1:0]   vx_q, vx_d, vy_q, vy_d;
  logic [MagW-1:0]          mx_q, mx_d, my_q, my_d;
  logic [ShW-1:0]           s_q, s_d;
  logic [RadW-1:0]          sqacc_q, sqacc_d;
  logic [LenW-1:0]          lmax_q, lmax_d;
  logic [TW-1:0]            dt_q, dt_d;
  logic signed [CoordW-1:0] rx_q, rx_d;
  logic signed [CoordW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
  logic [KindW-1:0]         res_kind_q, res_kind_d;
  logic                     res_last_q, res_last_d;

  // Unit connections
  logic [TolW-1:0]          tol;
  logic signed [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]         mul_b;
  logic signed [MulPW-1:0]  mul_p;
  logic                     div_start, div_done;
  logic [NumW-1:0]          div_num, div_quo;
  logic [LenW-1:0]          div_den;
  logic                     sqrt_start, sqrt_done;
  logic [RadW-1:0]          sqrt_rad;
  logic [RootW-1:0]         sqrt_root;

  // Combinational helpers
  logic                     req_acc, res_acc;
  logic signed [VecW-1:0]   ex0, ex1, ex2, ex3, ey0, ey1, ey2, ey3;
  logic signed [VecW-1:0]   d2x, d2y;
  logic [VecW-1:0]          ax, ay, am;
  logic [LenW-1:0]          len, lmax_new;
  logic [KW-1:0]            tol_k;
  logic signed [MulAW-1:0]  lerp_base, lerp_sum;
  logic signed [CoordW-1:0] lerp_res;
  logic [TW:0]              t_sum;

  bpf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tol_o   (tol)
  );

  bpf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  bpf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  bpf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign req_i.ready = (state_q == StIdle);
  assign req_acc     = req_i.valid && req_i.ready;
  assign res_acc     = res_o.valid && res_o.ready;

  assign res_o.valid       = (state_q == StEmit);
  assign res_o.out_x       = res_x_q;
  assign res_o.out_y       = res_y_q;
  assign res_o.seg_kind    = res_kind_q;
  assign res_o.last_of_run = res_last_q;

  // Second-difference terms of the control polygon
  assign ex0 = VecW'(px_q[0]);
  assign ex1 = VecW'(px_q[1]);
  assign ex2 = VecW'(px_q[2]);
  assign ex3 = VecW'(px_q[3]);
  assign ey0 = VecW'(py_q[0]);
  assign ey1 = VecW'(py_q[1]);
  assign ey2 = VecW'(py_q[2]);
  assign ey3 = VecW'(py_q[3]);
  assign d2x = ex0 - (ex1 <<< 1) + ex2;
  assign d2y = ey0 - (ey1 <<< 1) + ey2;

  // Component magnitudes for the length
  assign ax = vx_q[VecW-1] ? VecW'(-vx_q) : VecW'(vx_q);
  assign ay = vy_q[VecW-1] ? VecW'(-vy_q) : VecW'(vy_q);
  assign am = ax | ay;

  // Length and running maximum of the curvature bound
  assign len      = LenW'(sqrt_root) << s_q;
  assign lmax_new = (len > lmax_q) ? len : lmax_q;

  // Numerator of the step size
  assign tol_k   = KW'(tol) * Sqrt8Q16;
  assign div_num = cubic_q ? {tol_k, 16'b0} : {tol, 34'b0};
  assign div_den = lmax_new;

  // Interpolation result: a + floor((b - a) * t / 2^16)
  assign lerp_base = (state_q == StLy) ? MulAW'(wx_q[0]) : MulAW'(wy_q[0]);
  assign lerp_sum  = lerp_base + mul_p[MulAW+15:16];
  assign lerp_res  = lerp_sum[CoordW-1:0];

  assign t_sum = {1'b0, t_q} + {1'b0, dt_q};

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cubic_d    = cubic_q;
    pass_d     = pass_q;
    seg_d      = seg_q;
    t_d        = t_q;
    n_d        = n_q;
    k_d        = k_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    px_d       = px_q;
    py_d       = py_q;
    wx_d       = wx_q;
    wy_d       = wy_q;
    vx_d       = vx_q;
    vy_d       = vy_q;
    mx_d       = mx_q;
    my_d       = my_q;
    s_d        = s_q;
    sqacc_d    = sqacc_q;
    lmax_d     = lmax_q;
    dt_d       = dt_q;
    rx_d       = rx_q;
    res_x_d    = res_x_q;
    res_y_d    = res_y_q;
    res_kind_d = res_kind_q;
    res_last_d = res_last_q;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    sqrt_rad   = '0;

    case (state_q)
      StIdle: begin
        if (req_acc) begin
          px_d[0] = cur_x_q;
          py_d[0] = cur_y_q;
          px_d[1] = req_i.p1_x;
          py_d[1] = req_i.p1_y;
          px_d[2] = req_i.p2_x;
          py_d[2] = req_i.p2_y;
          px_d[3] = req_i.p3_x;
          py_d[3] = req_i.p3_y;
          cubic_d = (req_i.req_type == ReqCubic);
          pass_d  = 1'b0;
          t_d     = '0;
          seg_d   = '0;
          lmax_d  = '0;
          case (req_i.req_type)
            ReqMove, ReqLine: begin
              res_x_d    = sat_coord(req_i.p1_x);
              res_y_d    = sat_coord(req_i.p1_y);
              res_kind_d = (req_i.req_type == ReqMove) ? SegMove : SegLine;
              res_last_d = 1'b1;
              cur_x_d    = sat_coord(req_i.p1_x);
              cur_y_d    = sat_coord(req_i.p1_y);
              state_d    = StEmit;
            end
            ReqQuad: begin
              cur_x_d = sat_coord(req_i.p2_x);
              cur_y_d = sat_coord(req_i.p2_y);
              state_d = StVec;
            end
            ReqCubic: begin
              cur_x_d = sat_coord(req_i.p3_x);
              cur_y_d = sat_coord(req_i.p3_y);
              state_d = StVec;
            end
            default: begin
              res_x_d    = sat_coord(cur_x_q);
              res_y_d    = sat_coord(cur_y_q);
              res_kind_d = SegUnsup;
              res_last_d = 1'b1;
              state_d    = StEmit;
            end
          endcase
        end
      end

      // Vector whose length bounds the curvature
      StVec: begin
        if (!cubic_q) begin
          vx_d = d2x;
          vy_d = d2y;
        end else if (!pass_q) begin
          vx_d = d2x + (d2x <<< 1);
          vy_d = d2y + (d2y <<< 1);
        end else begin
          vx_d = (ex0 <<< 1) - (ex1 + (ex1 <<< 1)) + ex3;
          vy_d = (ey0 <<< 1) - (ey1 + (ey1 <<< 1)) + ey3;
        end
        state_d = StNorm;
      end

      // Scale both components below 2^31
      StNorm: begin
        s_d = '0;
        for (int i = 1; i <= VecW - MagW; i++) begin
          if ((am >> (MagW + i - 1)) != '0) begin
            s_d = ShW'(i);
          end
        end
        mx_d    = MagW'(ax >> s_d);
        my_d    = MagW'(ay >> s_d);
        state_d = StSqX;
      end

      StSqX: begin
        mul_a   = $signed({{(MulAW - MagW){1'b0}}, mx_q});
        mul_b   = mx_q;
        state_d = StSqY;
      end

      StSqY: begin
        mul_a   = $signed({{(MulAW - MagW){1'b0}}, my_q});
        mul_b   = my_q;
        sqacc_d = mul_p[RadW-1:0];
        state_d = StSqS;
      end

      StSqS: begin
        sqrt_start = 1'b1;
        sqrt_rad   = sqacc_q + mul_p[RadW-1:0];
        state_d    = StRoot;
      end

      // Length ready: second pass for a cubic, else the step size
      StRoot: begin
        if (sqrt_done) begin
          if (cubic_q && !pass_q) begin
            lmax_d  = len;
            pass_d  = 1'b1;
            state_d = StVec;
          end else begin
            lmax_d = lmax_new;
            if (lmax_new == '0) begin
              dt_d    = OneQ16;
              state_d = StPt;
            end else begin
              div_start = 1'b1;
              state_d   = StDiv;
            end
          end
        end
      end

      StDiv: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          sqrt_rad   = RadW'(div_quo);
          state_d    = StDtSq;
        end
      end

      // Clamp the step to [DtMin, 1.0]
      StDtSq: begin
        if (sqrt_done) begin
          if (sqrt_root > RootW'(OneQ16)) begin
            dt_d = OneQ16;
          end else if (sqrt_root < RootW'(DtMin)) begin
            dt_d = DtMin;
          end else begin
            dt_d = sqrt_root[TW-1:0];
          end
          state_d = StPt;
        end
      end

      // Advance t and reload the control points
      StPt: begin
        t_d     = (t_sum > {1'b0, OneQ16}) ? OneQ16 : t_sum[TW-1:0];
        seg_d   = seg_q + SegW'(1);
        wx_d    = px_q;
        wy_d    = py_q;
        n_d     = cubic_q ? 3'd4 : 3'd3;
        k_d     = '0;
        state_d = StLx;
      end

      StLx: begin
        mul_a   = MulAW'(wx_q[1]) - MulAW'(wx_q[0]);
        mul_b   = MulBW'(t_q);
        state_d = StLy;
      end

      StLy: begin
        mul_a   = MulAW'(wy_q[1]) - MulAW'(wy_q[0]);
        mul_b   = MulBW'(t_q);
        rx_d    = lerp_res;
        state_d = StLw;
      end

      // Rotate the level window and append the new point
      StLw: begin
        for (int j = 0; j < 3; j++) begin
          if (3'(j + 1) < n_q) begin
            wx_d[j] = wx_q[j + 1];
            wy_d[j] = wy_q[j + 1];
          end
        end
        for (int j = 0; j < 4; j++) begin
          if (3'(j) == n_q - 3'd1) begin
            wx_d[j] = rx_q;
            wy_d[j] = lerp_res;
          end
        end
        if (k_q == 2'(n_q - 3'd2)) begin
          state_d = StDrop;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = StLx;
        end
      end

      // Drop the oldest point of the level; the final level gives the point
      StDrop: begin
        if (n_q == 3'd2) begin
          res_x_d    = sat_coord(wx_q[1]);
          res_y_d    = sat_coord(wy_q[1]);
          res_kind_d = SegLine;
          res_last_d = (t_q == OneQ16) || (seg_q == SegW'(MAX_SEGMENTS));
          state_d    = StEmit;
        end else begin
          for (int j = 0; j < 3; j++) begin
            if (3'(j + 1) < n_q) begin
              wx_d[j] = wx_q[j + 1];
              wy_d[j] = wy_q[j + 1];
            end
          end
          n_d     = n_q - 3'd1;
          k_d     = '0;
          state_d = StLx;
        end
      end

      StEmit: begin
        if (res_acc) begin
          state_d = res_last_q ? StIdle : StPt;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cubic_q <= 1'b0;
      pass_q  <= 1'b0;
      seg_q   <= '0;
      t_q     <= '0;
      n_q     <= '0;
      k_q     <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
    end else begin
      state_q <= state_d;
      cubic_q <= cubic_d;
      pass_q  <= pass_d;
      seg_q   <= seg_d;
      t_q     <= t_d;
      n_q     <= n_d;
      k_q     <= k_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q       <= px_d;
    py_q       <= py_d;
    wx_q       <= wx_d;
    wy_q       <= wy_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    mx_q       <= mx_d;
    my_q       <= my_d;
    s_q        <= s_d;
    sqacc_q    <= sqacc_d;
    lmax_q     <= lmax_d;
    dt_q       <= dt_d;
    rx_q       <= rx_d;
    res_x_q    <= res_x_d;
    res_y_q    <= res_y_d;
    res_kind_q <= res_kind_d;
    res_last_q <= res_last_d;
  end

  // A command is never taken while a point is still on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && res_o.valid))
    else $error("command accepted while a result is pending");

  // The segment count never passes its bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= SegW'(MAX_SEGMENTS))
    else $error("segment count beyond its bound");

  // The final item of a command frees the input channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_acc && res_o.last_of_run) |=> req_i.ready)
    else $error("not ready after the last item of a command");

endmodule

### rtl/bpf_cfg.sv
// APB-style register port holding the flattening tolerance.
// Depends on bpf_pkg.
module bpf_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpf_pkg::ApbAW-1:0]  paddr,
  input  logic [bpf_pkg::ApbDW-1:0]  pwdata,
  output logic [bpf_pkg::ApbDW-1:0]  prdata,
  output logic                       pready,
  output logic [bpf_pkg::TolW-1:0]   tol_o
);
  import bpf_pkg::*;

  logic [TolW-1:0] tol_q, tol_d;
  logic            reg_idx;

  assign reg_idx = paddr[ApbAW-1];
  assign pready  = 1'b1;

  // Register write in the access phase
  always_comb begin
    tol_d = tol_q;
    if (psel && penable && pwrite && (reg_idx == RegTolerance)) begin
      tol_d = pwdata[TolW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else begin
      tol_q <= tol_d;
    end
  end

  // Read back
  assign prdata = (reg_idx == RegTolerance) ? ApbDW'(tol_q) : '0;
  assign tol_o  = tol_q;

endmodule

### rtl/bpf_mul.sv
// Shared signed-by-unsigned multiplier with a registered product, used for
// squaring vector components and for the interpolation steps. Depends on bpf_pkg.
module bpf_mul (
  input  logic                              clk_i,
  input  logic signed [bpf_pkg::MulAW-1:0]  a_i,
  input  logic [bpf_pkg::MulBW-1:0]         b_i,
  output logic signed [bpf_pkg::MulPW-1:0]  p_o
);
  import bpf_pkg::*;

  logic signed [MulPW:0]   full;
  logic signed [MulPW-1:0] p_q;

  // Operand b is widened with a zero sign bit
  always_comb begin
    full = a_i * $signed({1'b0, b_i});
  end

  always_ff @(posedge clk_i) begin
    p_q <= full[MulPW-1:0];
  end

  assign p_o = p_q;

endmodule

### rtl/bpf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, for the step size.
// Depends on bpf_pkg.
module bpf_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bpf_pkg::NumW-1:0]   num_i,
  input  logic [bpf_pkg::LenW-1:0]   den_i,
  output logic                       done_o,
  output logic [bpf_pkg::NumW-1:0]   quo_o
);
  import bpf_pkg::*;

  localparam int CntW = $clog2(NumW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [LenW-1:0] den_q, den_d;
  logic [LenW:0]   rem_sh;

  // One shift-and-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q, quo_q[NumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = LenW'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[LenW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/bpf_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle, shared by the
// vector length and the step size. Depends on bpf_pkg.
module bpf_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bpf_pkg::RadW-1:0]    rad_i,
  output logic                        done_o,
  output logic [bpf_pkg::RootW-1:0]   root_o
);
  import bpf_pkg::*;

  localparam int CntW = $clog2(RootW);
  localparam int RemW = RootW + 3;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [RadW-1:0]  rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [RootW-1:0] root_q, root_d;
  logic [RemW-1:0]  rem_sh;
  logic [RemW-1:0]  trial;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d = {rad_q[RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
